[design/clsr_pkg.sv]
package clsr_pkg;

  // generator and table geometry
  localparam int GEN_W       = 31;
  localparam int TABLE_DEPTH = 32;
  localparam int TAB_IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WARM_STEPS  = TABLE_DEPTH + 8;
  localparam int CNT_W       = $clog2(WARM_STEPS);

  // combined output range
  localparam longint SPAN_L = 64'd2147483562;
  localparam logic [GEN_W-1:0] SPAN       = GEN_W'(SPAN_L);
  localparam logic [GEN_W-1:0] CEIL_LIMIT = 31'd2147483305;

  // slot = shuffle output / SLOT_DIV via reciprocal plus one correction
  localparam longint SLOT_DIV_L   = 64'd1 + SPAN_L / TABLE_DEPTH;
  localparam int     SLOT_SH      = 48;
  localparam int     SLOT_QW      = 8;
  localparam int     SLOT_PROD_W  = GEN_W + 32;
  localparam int     SLOT_QD_W    = SLOT_QW + GEN_W;
  localparam logic [GEN_W-1:0] SLOT_DIV   = GEN_W'(SLOT_DIV_L);
  localparam logic [31:0]      SLOT_RECIP = 32'((64'd1 << SLOT_SH) / SLOT_DIV_L);

  // schrage lane: k = x / q by reciprocal, then fixed by one compare
  localparam int LANE_SH = 47;
  localparam int K_W     = 16;
  localparam int PROD_W  = GEN_W + 32;

  localparam longint QUO_A_L = 64'd53668;
  localparam longint QUO_B_L = 64'd52774;

  typedef struct packed {
    logic [K_W-1:0]   q;
    logic [31:0]      recip;
    logic [K_W-1:0]   mul;
    logic [K_W-1:0]   rem;
    logic [GEN_W-1:0] modulus;
  } lane_const_t;

  localparam lane_const_t LANE_A = '{
    q:       16'd53668,
    recip:   32'((64'd1 << LANE_SH) / QUO_A_L),
    mul:     16'd40014,
    rem:     16'd12211,
    modulus: 31'd2147483563
  };

  localparam lane_const_t LANE_B = '{
    q:       16'd52774,
    recip:   32'((64'd1 << LANE_SH) / QUO_B_L),
    mul:     16'd40692,
    rem:     16'd3791,
    modulus: 31'd2147483399
  };

  localparam logic [GEN_W-1:0] INIT_A = 31'd1;
  localparam logic [GEN_W-1:0] INIT_B = 31'd123456789;

  // microcode
  typedef enum logic [2:0] {
    L_NOP,
    L_LOAD,
    L_MULR,
    L_MULQ,
    L_FIX,
    L_MULAB,
    L_FIN
  } lane_op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_LOOP,
    C_WAIT_GO
  } seq_cond_e;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_RS_LOAD  = 4'd1;
  localparam logic [PC_W-1:0] PC_W_MULR   = 4'd2;
  localparam logic [PC_W-1:0] PC_W_MULQ   = 4'd3;
  localparam logic [PC_W-1:0] PC_W_FIX    = 4'd4;
  localparam logic [PC_W-1:0] PC_W_MULAB  = 4'd5;
  localparam logic [PC_W-1:0] PC_W_FIN    = 4'd6;
  localparam logic [PC_W-1:0] PC_W_STORE  = 4'd7;
  localparam logic [PC_W-1:0] PC_D_MULR   = 4'd8;
  localparam logic [PC_W-1:0] PC_D_MULQ   = 4'd9;
  localparam logic [PC_W-1:0] PC_D_FIX    = 4'd10;
  localparam logic [PC_W-1:0] PC_D_MULAB  = 4'd11;
  localparam logic [PC_W-1:0] PC_D_FIN    = 4'd12;
  localparam logic [PC_W-1:0] PC_D_EMIT   = 4'd13;

  typedef struct packed {
    lane_op_e        lane_op;
    logic            en_b;
    logic            cnt_load;
    logic            slot_mul;
    logic            slot_fix;
    logic            tab_rd;
    logic            tab_wr_warm;
    logic            tab_wr_draw;
    logic            emit;
    seq_cond_e       cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic                 slot_mul;
    logic                 slot_fix;
    logic                 rd_en;
    logic                 wr_en;
    logic                 wr_slot;
    logic [TAB_IDX_W-1:0] warm_idx;
  } tab_req_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w         = '0;
    w.lane_op = L_NOP;
    w.cond    = C_NEXT;
    w.target  = PC_IDLE;
    case (pc)
      PC_IDLE: begin
        w.cond   = C_DISPATCH;
        w.target = PC_D_MULR;
      end
      PC_RS_LOAD: begin
        w.lane_op  = L_LOAD;
        w.en_b     = 1'b1;
        w.cnt_load = 1'b1;
      end
      PC_W_MULR:  w.lane_op = L_MULR;
      PC_W_MULQ:  w.lane_op = L_MULQ;
      PC_W_FIX:   w.lane_op = L_FIX;
      PC_W_MULAB: w.lane_op = L_MULAB;
      PC_W_FIN:   w.lane_op = L_FIN;
      PC_W_STORE: begin
        w.tab_wr_warm = 1'b1;
        w.cond        = C_LOOP;
        w.target      = PC_W_MULR;
      end
      PC_D_MULR: begin
        w.lane_op  = L_MULR;
        w.en_b     = 1'b1;
        w.slot_mul = 1'b1;
      end
      PC_D_MULQ: begin
        w.lane_op  = L_MULQ;
        w.en_b     = 1'b1;
        w.slot_fix = 1'b1;
      end
      PC_D_FIX: begin
        w.lane_op = L_FIX;
        w.en_b    = 1'b1;
        w.tab_rd  = 1'b1;
      end
      PC_D_MULAB: begin
        w.lane_op = L_MULAB;
        w.en_b    = 1'b1;
      end
      PC_D_FIN: begin
        w.lane_op = L_FIN;
        w.en_b    = 1'b1;
      end
      PC_D_EMIT: begin
        w.emit        = 1'b1;
        w.tab_wr_draw = 1'b1;
        w.cond        = C_WAIT_GO;
        w.target      = PC_IDLE;
      end
      default: begin
        w.cond   = C_JUMP;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[design/combined_lcg_shuffle_rng.sv]
// combined two-generator random source with a 32-entry shuffle table
//
// input channel: in_valid_i / in_stall_o carry one request of operation_i and
// seed_value_i. operation_i low asks for the next draw; high reseeds both
// generators with seed_value_i (zero taken as one), runs the 40-step warm-up
// that refills the shuffle table, then draws.
// output channel: out_valid_o / out_stall_i carry random_value_o (1 to
// 2147483562, fraction = value / 2147483563) and at_ceiling_o, set when a
// floating-point fraction would be clamped just below one.
// the input stalls until the program is back in idle, so a new request is
// taken only once the last one is done; each schrage update is five
// microsteps of the multiply lanes and the warm-up runs forty of them in a
// row on the first lane.
// the output register lets the next request start while a result waits;
// if out_stall_i still holds the old result, the emit step stalls there.
// reset: generators go to 1 and 123456789, the shuffle output and the whole
// table read as zero, output channel empty.
module combined_lcg_shuffle_rng (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [clsr_pkg::GEN_W-1:0] seed_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [clsr_pkg::GEN_W-1:0] random_value_o,
  output logic                       at_ceiling_o
);
  import clsr_pkg::*;

  // sequencer outputs
  ucode_t           uc;
  logic             go;
  logic             idle;
  logic [CNT_W-1:0] cnt;

  logic             in_fire;
  logic             out_busy;
  logic             emit_go;
  logic             warm_go;
  logic             warm_in_range;

  // generator state and shuffle output
  logic [GEN_W-1:0] x_a_q, x_b_q;
  logic [GEN_W-1:0] nx_a, nx_b;
  logic [GEN_W-1:0] seed_q;
  logic [GEN_W-1:0] shuf_q;

  logic             en_b;
  tab_req_t         tab_req;
  logic [GEN_W-1:0] tab_rdata;

  // result combine
  logic [GEN_W:0]   mix_diff;
  logic [GEN_W-1:0] mixed;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [GEN_W-1:0] rand_q;
  logic             ceil_q;

  assign in_stall_o = !idle;
  assign in_fire    = in_valid_i && idle;
  assign out_busy   = out_valid_q && out_stall_i;

  clsr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .reseed_i   (operation_i),
    .out_busy_i (out_busy),
    .uc_o       (uc),
    .go_o       (go),
    .idle_o     (idle),
    .cnt_o      (cnt)
  );

  assign en_b = go && uc.en_b;

  // two schrage lanes share the same microcode word
  clsr_lane u_lane_a (
    .clk_i    (clk_i),
    .op_i     (uc.lane_op),
    .en_i     (go),
    .x_i      (x_a_q),
    .k_i      (LANE_A),
    .x_next_o (nx_a)
  );

  clsr_lane u_lane_b (
    .clk_i    (clk_i),
    .op_i     (uc.lane_op),
    .en_i     (en_b),
    .x_i      (x_b_q),
    .k_i      (LANE_B),
    .x_next_o (nx_b)
  );

  // seed capture, zero taken as one
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      seed_q <= (seed_value_i == '0) ? GEN_W'(1) : seed_value_i;
    end
  end

  // generator registers update on load and on the final lane step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_a_q <= INIT_A;
      x_b_q <= INIT_B;
    end else if (go && (uc.lane_op == L_LOAD)) begin
      x_a_q <= seed_q;
      x_b_q <= seed_q;
    end else if (go && (uc.lane_op == L_FIN)) begin
      x_a_q <= nx_a;
      if (uc.en_b) begin
        x_b_q <= nx_b;
      end
    end
  end

  // warm-up fills from the top entry down; only the last entries are kept
  assign warm_go       = go && uc.tab_wr_warm;
  assign warm_in_range = (cnt < CNT_W'(TABLE_DEPTH));
  assign emit_go       = go && uc.emit;

  always_comb begin
    tab_req          = '0;
    tab_req.slot_mul = go && uc.slot_mul;
    tab_req.slot_fix = go && uc.slot_fix;
    tab_req.rd_en    = go && uc.tab_rd;
    tab_req.wr_en    = (go && uc.tab_wr_draw) || (warm_go && warm_in_range);
    tab_req.wr_slot  = uc.tab_wr_draw;
    tab_req.warm_idx = TAB_IDX_W'(cnt);
  end

  clsr_tab u_tab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tab_req),
    .y_i     (shuf_q),
    .wdata_i (x_a_q),
    .rdata_o (tab_rdata)
  );

  // table entry minus second generator, wrapped into 1..span
  assign mix_diff = {1'b0, tab_rdata} - {1'b0, x_b_q};
  assign mixed    = (mix_diff[GEN_W] || (mix_diff == '0))
                  ? GEN_W'(mix_diff + (GEN_W + 1)'(SPAN))
                  : GEN_W'(mix_diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shuf_q <= '0;
    end else if (warm_go && (cnt == '0)) begin
      // entry 0 seeds the shuffle output
      shuf_q <= x_a_q;
    end else if (emit_go) begin
      shuf_q <= mixed;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_go) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      rand_q <= mixed;
      ceil_q <= (mixed > CEIL_LIMIT);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = rand_q;
  assign at_ceiling_o   = ceil_q;

  // a taken request blocks the input until its program has run
  a_busy_after_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input not stalled after request taken");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (random_value_o != '0) && (random_value_o <= SPAN))
    else $error("result outside 1..span");

  a_ceiling_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (at_ceiling_o == (random_value_o > CEIL_LIMIT)))
    else $error("ceiling flag does not match value");

  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(emit_go))
    else $error("result appeared without an emit step");

endmodule

[design/clsr_seq.sv]
module clsr_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_fire_i,
  input  logic                      reseed_i,
  input  logic                      out_busy_i,
  output clsr_pkg::ucode_t          uc_o,
  output logic                      go_o,
  output logic                      idle_o,
  output logic [clsr_pkg::CNT_W-1:0] cnt_o
);
  import clsr_pkg::*;

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  ucode_t           uc;
  logic             go;

  assign uc = ucode_rom(pc_q);

  always_comb begin
    pc_d  = pc_q + 1'b1;
    cnt_d = cnt_q;
    go    = 1'b1;
    case (uc.cond)
      C_NEXT: ;
      C_JUMP: pc_d = uc.target;
      C_DISPATCH: begin
        if (!in_fire_i) begin
          pc_d = pc_q;
        end else if (!reseed_i) begin
          pc_d = uc.target;
        end
      end
      C_LOOP: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
          pc_d  = uc.target;
        end
      end
      C_WAIT_GO: begin
        if (out_busy_i) begin
          pc_d = pc_q;
          go   = 1'b0;
        end else begin
          pc_d = uc.target;
        end
      end
      default: pc_d = PC_IDLE;
    endcase
    if (uc.cnt_load) begin
      cnt_d = CNT_W'(WARM_STEPS - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PC_IDLE;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

  assign uc_o   = uc;
  assign go_o   = go;
  assign idle_o = (pc_q == PC_IDLE);
  assign cnt_o  = cnt_q;

endmodule

[design/clsr_lane.sv]
module clsr_lane (
  input  logic                       clk_i,
  input  clsr_pkg::lane_op_e         op_i,
  input  logic                       en_i,
  input  logic [clsr_pkg::GEN_W-1:0] x_i,
  input  clsr_pkg::lane_const_t      k_i,
  output logic [clsr_pkg::GEN_W-1:0] x_next_o
);
  import clsr_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic [K_W-1:0]    k_q;
  logic [K_W-1:0]    rem_q;
  logic [31:0]       kq_q;
  logic [31:0]       ta_q;
  logic [31:0]       tb_q;
  logic [K_W-1:0]    k0;
  logic [31:0]       rem0;
  logic [32:0]       diff;

  // quotient estimate is exact or one low
  assign k0   = prod_q[LANE_SH +: K_W];
  assign rem0 = 32'(x_i) - kq_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (op_i)
        L_MULR:  prod_q <= PROD_W'(x_i) * PROD_W'(k_i.recip);
        L_MULQ: begin
          k_q  <= k0;
          kq_q <= 32'(k0) * 32'(k_i.q);
        end
        L_FIX: begin
          if (rem0 >= 32'(k_i.q)) begin
            k_q   <= k_q + 1'b1;
            rem_q <= K_W'(rem0 - 32'(k_i.q));
          end else begin
            rem_q <= K_W'(rem0);
          end
        end
        L_MULAB: begin
          ta_q <= 32'(k_i.mul) * 32'(rem_q);
          tb_q <= 32'(k_q) * 32'(k_i.rem);
        end
        default: ;
      endcase
    end
  end

  // wrap a negative difference back into the modulus
  assign diff     = {1'b0, ta_q} - {1'b0, tb_q};
  assign x_next_o = diff[32] ? GEN_W'(diff + 33'(k_i.modulus)) : GEN_W'(diff);

endmodule

[design/clsr_tab.sv]
module clsr_tab (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  clsr_pkg::tab_req_t         req_i,
  input  logic [clsr_pkg::GEN_W-1:0] y_i,
  input  logic [clsr_pkg::GEN_W-1:0] wdata_i,
  output logic [clsr_pkg::GEN_W-1:0] rdata_o
);
  import clsr_pkg::*;

  logic [GEN_W-1:0]       mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_q;
  logic                   rdv_q;
  logic [GEN_W-1:0]       rd_q;
  logic [SLOT_QW-1:0]     q0_q;
  logic [TAB_IDX_W-1:0]   slot_q;
  logic [TAB_IDX_W-1:0]   slot_d;
  logic [TAB_IDX_W-1:0]   widx;
  logic [SLOT_PROD_W-1:0] sprod;
  logic [SLOT_QD_W-1:0]   qd;
  logic [GEN_W:0]         srem;
  logic [SLOT_QW-1:0]     qf;

  // slot quotient: reciprocal estimate, then one correction step
  assign sprod  = SLOT_PROD_W'(y_i) * SLOT_PROD_W'(SLOT_RECIP);
  assign qd     = SLOT_QD_W'(q0_q) * SLOT_QD_W'(SLOT_DIV);
  assign srem   = {1'b0, y_i} - (GEN_W + 1)'(qd);
  assign qf     = (srem >= (GEN_W + 1)'(SLOT_DIV)) ? q0_q + 1'b1 : q0_q;
  assign slot_d = (qf >= SLOT_QW'(TABLE_DEPTH)) ? TAB_IDX_W'(TABLE_DEPTH - 1)
                                                : TAB_IDX_W'(qf);
  assign widx   = req_i.wr_slot ? slot_q : req_i.warm_idx;

  always_ff @(posedge clk_i) begin
    if (req_i.slot_mul) begin
      q0_q <= sprod[SLOT_SH +: SLOT_QW];
    end
    if (req_i.slot_fix) begin
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[widx] <= wdata_i;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[slot_q];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rdv_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[widx] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rdv_q <= vld_q[slot_q];
      end
    end
  end

  assign rdata_o = rdv_q ? rd_q : '0;

endmodule
